// File: rtl/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue.
// Used by spq_cell, sorted_priority_queue_unit and spq_checker. No dependencies.
`default_nettype none

package spq_pkg;

  // item command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int DATA_WIDTH = 32;

  // what a cell does on the next clock edge
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD_NEW  = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// spq_cell: one slot of the sorted chain (data word and priority).
// Depends on spq_pkg.
`default_nettype none

module spq_cell #(
  parameter int PRIO_WIDTH = 8
) (
  input  wire logic                                   clk,
  input  wire spq_pkg::cell_ctl_t                     ctl,
  input  wire logic                                   occupied,
  input  wire logic signed [spq_pkg::DATA_WIDTH-1:0]  new_data,
  input  wire logic        [PRIO_WIDTH-1:0]           new_prio,
  input  wire logic signed [spq_pkg::DATA_WIDTH-1:0]  prev_data,
  input  wire logic        [PRIO_WIDTH-1:0]           prev_prio,
  input  wire logic signed [spq_pkg::DATA_WIDTH-1:0]  next_data,
  input  wire logic        [PRIO_WIDTH-1:0]           next_prio,
  output logic                                        take,
  output logic signed      [spq_pkg::DATA_WIDTH-1:0]  data,
  output logic             [PRIO_WIDTH-1:0]           prio
);

  logic signed [spq_pkg::DATA_WIDTH-1:0] data_r, data_nxt;
  logic        [PRIO_WIDTH-1:0]          prio_r, prio_nxt;

  // slot is free, or holds something strictly below the incoming priority
  assign take = !occupied || (prio_r < new_prio);

  always_comb begin
    unique case (ctl.op)
      spq_pkg::CELL_HOLD: begin
        data_nxt = data_r;
        prio_nxt = prio_r;
      end
      spq_pkg::CELL_LOAD_NEW: begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end
      spq_pkg::CELL_FROM_PREV: begin
        data_nxt = prev_data;
        prio_nxt = prev_prio;
      end
      spq_pkg::CELL_FROM_NEXT: begin
        data_nxt = next_data;
        prio_nxt = next_prio;
      end
      default: begin
        data_nxt = data_r;
        prio_nxt = prio_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue_unit.sv
// sorted_priority_queue_unit: top level of the sorted priority queue.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue of DEPTH entries held as a chain of cells, kept
// sorted with the highest priority at the head (cell 0). Every input item
// is either an insert (data word plus priority) or a remove of the head,
// and produces exactly one result item carrying a status, the removed
// entry (zero on insert or on a failed remove) and the occupancy after
// the operation. Inserts go behind all held entries of equal or higher
// priority, so equal priorities leave in arrival order. An insert on a
// full queue is dropped with status full; a remove on an empty queue
// reports status empty. Every cell compares its own priority against the
// incoming one in parallel and either holds, loads the new entry, or
// takes its neighbour's entry, so the whole chain updates on the
// accepting edge. The result sits in an output register; a new item is
// accepted whenever that register is empty or being drained in the same
// cycle, giving one item per cycle with out_ready held high. No clearing
// pass is needed after reset: only the entry count and the result valid
// flag are reset, and slots beyond the count are never read.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int DEPTH      = 16,
  parameter int PRIO_WIDTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // input items
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_cmd,
  input  wire logic signed [spq_pkg::DATA_WIDTH-1:0]  in_entry_data,
  input  wire logic        [PRIO_WIDTH-1:0]           in_entry_priority,
  // result items
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic             [1:0]                      out_status,
  output logic signed      [spq_pkg::DATA_WIDTH-1:0]  out_data,
  output logic             [PRIO_WIDTH-1:0]           out_priority,
  output logic             [$clog2(DEPTH+1)-1:0]      out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  // chain wiring
  logic signed [spq_pkg::DATA_WIDTH-1:0] cell_data [DEPTH];
  logic        [PRIO_WIDTH-1:0]          cell_prio [DEPTH];
  logic        [DEPTH-1:0]               cell_take;
  logic        [DEPTH-1:0]               cell_occ;
  spq_pkg::cell_ctl_t                    cell_ctl  [DEPTH];

  // occupancy
  logic [CW-1:0] count_r, count_nxt;
  logic          full, empty;

  // handshake and operation decode
  logic accept, do_ins, do_rem;

  // result register
  logic                                  out_valid_r, out_valid_nxt;
  logic [1:0]                            status_r, status_nxt;
  logic signed [spq_pkg::DATA_WIDTH-1:0] odata_r, odata_nxt;
  logic [PRIO_WIDTH-1:0]                 oprio_r, oprio_nxt;
  logic [CW-1:0]                         occ_r, occ_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // the result register is free or being emptied this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign do_ins   = accept && (in_cmd == spq_pkg::CMD_INSERT) && !full;
  assign do_rem   = accept && (in_cmd == spq_pkg::CMD_REMOVE) && !empty;

  // per-cell control: the first taking cell loads the new entry, the ones
  // behind it shift back by one; on remove all but the last cell move forward
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < count_r);

    always_comb begin
      priority if (do_ins) begin
        if (!cell_take[i])
          cell_ctl[i].op = spq_pkg::CELL_HOLD;
        else if (i == 0)
          cell_ctl[i].op = spq_pkg::CELL_LOAD_NEW;
        else if (cell_take[(i == 0) ? 0 : i-1])
          cell_ctl[i].op = spq_pkg::CELL_FROM_PREV;
        else
          cell_ctl[i].op = spq_pkg::CELL_LOAD_NEW;
      end else if (do_rem && (i < DEPTH-1)) begin
        cell_ctl[i].op = spq_pkg::CELL_FROM_NEXT;
      end else begin
        cell_ctl[i].op = spq_pkg::CELL_HOLD;
      end
    end

    spq_cell #(
      .PRIO_WIDTH (PRIO_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .occupied  (cell_occ[i]),
      .new_data  (in_entry_data),
      .new_prio  (in_entry_priority),
      .prev_data (cell_data[(i == 0) ? 0 : i-1]),
      .prev_prio (cell_prio[(i == 0) ? 0 : i-1]),
      .next_data (cell_data[(i == DEPTH-1) ? DEPTH-1 : i+1]),
      .next_prio (cell_prio[(i == DEPTH-1) ? DEPTH-1 : i+1]),
      .take      (cell_take[i]),
      .data      (cell_data[i]),
      .prio      (cell_prio[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins)
      count_nxt = count_r + CW'(1);
    else if (do_rem)
      count_nxt = count_r - CW'(1);
  end

  // result item built on the accepting edge
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    odata_nxt     = odata_r;
    oprio_nxt     = oprio_r;
    occ_nxt       = occ_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      occ_nxt       = count_nxt;
      odata_nxt     = '0;
      oprio_nxt     = '0;
      if (in_cmd == spq_pkg::CMD_INSERT) begin
        status_nxt = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end else if (empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        status_nxt = spq_pkg::ST_OK;
        odata_nxt  = cell_data[0];
        oprio_nxt  = cell_prio[0];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    odata_r  <= odata_nxt;
    oprio_r  <= oprio_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data      = odata_r;
  assign out_priority  = oprio_r;
  assign out_occupancy = occ_r;

endmodule

`default_nettype wire

// File: rtl/spq_checker.sv
// spq_checker: port-level assertions for sorted_priority_queue_unit, and its bind.
// Depends on spq_pkg.
`default_nettype none

module spq_checker #(
  parameter int DEPTH      = 16,
  parameter int PRIO_WIDTH = 8
) (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   out_valid,
  input wire logic                                   out_ready,
  input wire logic             [1:0]                 out_status,
  input wire logic signed [spq_pkg::DATA_WIDTH-1:0]  out_data,
  input wire logic             [PRIO_WIDTH-1:0]      out_priority,
  input wire logic             [$clog2(DEPTH+1)-1:0] out_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  // occupancy never exceeds the chain length
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CW'(DEPTH)))
    else $error("occupancy above depth");

  // an empty report means nothing held and nothing returned
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == spq_pkg::ST_EMPTY)) |->
      ((out_occupancy == '0) && (out_data == '0) && (out_priority == '0)))
    else $error("empty result inconsistent");

  // a full report means the chain is at depth and nothing returned
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == spq_pkg::ST_FULL)) |->
      ((out_occupancy == CW'(DEPTH)) && (out_data == '0)))
    else $error("full result inconsistent");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_data) && $stable(out_occupancy) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .DEPTH      (DEPTH),
  .PRIO_WIDTH (PRIO_WIDTH)
) u_spq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_data      (out_data),
  .out_priority  (out_priority),
  .out_occupancy (out_occupancy)
);

`default_nettype wire
